/* rtl/keypad_code_map_autorepeat_top_macros.svh */
// Assertion macros shared by the keypad repeat blocks.
// Each macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef KEYPAD_CODE_MAP_AUTOREPEAT_TOP_MACROS_SVH
`define KEYPAD_CODE_MAP_AUTOREPEAT_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define KCMA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define KCMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KCMA_ASSERT_NOW(label, ante, cons, msg)
`define KCMA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* rtl/kcma_pkg.sv */
`default_nettype none

package kcma_pkg;

  // Timer width and the width used to compare timers against the registers.
  localparam int TIME_BITS = 16;
  localparam int CFG_BITS = 16;
  localparam int CMP_BITS = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

  localparam int MAP_SIZE = 17;
  localparam int CODE_BITS = 10;
  localparam int BUTTON_BITS = 5;
  localparam int ETYPE_BITS = 5;
  localparam int VALUE_BITS = 2;
  localparam int CFG_INDEX_BITS = 4;

  localparam logic [BUTTON_BITS-1:0] DIR_FIRST = BUTTON_BITS'(11);
  localparam logic [BUTTON_BITS-1:0] DIR_LAST = BUTTON_BITS'(14);

  localparam logic [ETYPE_BITS-1:0] EV_KEY = ETYPE_BITS'(1);
  localparam logic [VALUE_BITS-1:0] KEY_RELEASE = VALUE_BITS'(0);
  localparam logic [VALUE_BITS-1:0] KEY_PRESS = VALUE_BITS'(1);

  localparam logic [CFG_INDEX_BITS-1:0] CFG_REPEAT_DELAY = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_REPEAT_PERIOD = CFG_INDEX_BITS'(1);

  localparam logic [CFG_BITS-1:0] RESET_DELAY = CFG_BITS'(300);
  localparam logic [CFG_BITS-1:0] RESET_PERIOD = CFG_BITS'(80);

  typedef enum logic {
    CMD_EVENT = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_t;

  // Scan code of each button, by button index.
  localparam logic [CODE_BITS-1:0] CODE_TABLE [MAP_SIZE] = '{
    10'd57, 10'd29, 10'd42, 10'd56, 10'd15, 10'd14, 10'd18, 10'd20, 10'd97,
    10'd28, 10'd1, 10'd103, 10'd108, 10'd105, 10'd106, 10'd115, 10'd114
  };

  // Request after the input register.
  typedef struct packed {
    logic                   cmd;
    logic [ETYPE_BITS-1:0]  event_type;
    logic [CODE_BITS-1:0]   key_code;
    logic [VALUE_BITS-1:0]  key_value;
  } request_t;

  // Decoded key event.
  typedef struct packed {
    logic                   key_ok;
    logic                   press;
    logic [BUTTON_BITS-1:0] button;
  } key_dec_t;

  typedef struct packed {
    logic [BUTTON_BITS-1:0] button;
    logic                   pressed;
    logic                   is_repeat;
  } result_t;

endpackage

`default_nettype wire

/* rtl/keypad_code_map_autorepeat_top.sv */
// Channel  Direction  Payload                                  Handshake
// in       request    cmd, event_type, key_code, key_value     in_valid / in_ready
// out      result     button, pressed, is_repeat               out_valid / out_ready
// cfg      write      cfg_index, cfg_data                      cfg_valid / cfg_ready
//
// One request per cycle while the output buffer has room: a request is held in the input
// register, then the table compare and timer update write its result, if any, into a
// two-entry output buffer. The buffer holds up to two results while out_ready is low;
// when it is full, the request waits in the input register and in_ready drops.
// Reset (rst, synchronous) restores delay 300 and period 80 and drops any held button.
// Configuration writes are always taken (cfg_ready stays high).
`default_nettype none

module keypad_code_map_autorepeat_top (
  input  var logic                                 clk,
  input  var logic                                 rst,
  input  var logic                                 in_valid,
  output var logic                                 in_ready,
  input  var logic                                 cmd,
  input  var logic [kcma_pkg::ETYPE_BITS-1:0]     event_type,
  input  var logic [kcma_pkg::CODE_BITS-1:0]      key_code,
  input  var logic [kcma_pkg::VALUE_BITS-1:0]     key_value,
  output var logic                                 out_valid,
  input  var logic                                 out_ready,
  output var logic [kcma_pkg::BUTTON_BITS-1:0]    button,
  output var logic                                 pressed,
  output var logic                                 is_repeat,
  input  var logic                                 cfg_valid,
  output var logic                                 cfg_ready,
  input  var logic [kcma_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  var logic [kcma_pkg::CFG_BITS-1:0]       cfg_data
);
  import kcma_pkg::*;

  logic     req_valid;
  request_t req;
  logic     advance;
  logic     space;
  key_dec_t dec;
  logic     res_valid;
  result_t  res;
  result_t  out_data;

  // Advance the held request whenever the buffer has room for its possible result.
  assign advance   = req_valid && space;
  assign in_ready  = !req_valid || space;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  // Capture the request payload; hold it while stalled.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req.cmd        <= cmd;
      req.event_type <= event_type;
      req.key_code   <= key_code;
      req.key_value  <= key_value;
    end
  end

  kcma_decode u_decode (
    .req (req),
    .dec (dec)
  );

  kcma_repeat u_repeat (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .req       (req),
    .dec       (dec),
    .res_valid (res_valid),
    .res       (res)
  );

  kcma_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (advance && res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign button    = out_data.button;
  assign pressed   = out_data.pressed;
  assign is_repeat = out_data.is_repeat;

endmodule

`default_nettype wire

/* rtl/kcma_decode.sv */
`default_nettype none

module kcma_decode (
  input  var kcma_pkg::request_t req,
  output var kcma_pkg::key_dec_t dec
);
  import kcma_pkg::*;

  logic [MAP_SIZE-1:0]    match;
  logic [BUTTON_BITS-1:0] idx;

  // Compare against every table entry at once; codes in the table are distinct.
  always_comb begin
    idx = '0;
    for (int i = 0; i < MAP_SIZE; i++) begin
      match[i] = (CODE_TABLE[i] == req.key_code);
      if (match[i]) begin
        idx = idx | BUTTON_BITS'(i);
      end
    end
  end

  always_comb begin
    dec.key_ok = (req.event_type == EV_KEY) && (req.key_value <= KEY_PRESS) && (|match);
    dec.press  = (req.key_value == KEY_PRESS);
    dec.button = idx;
  end

endmodule

`default_nettype wire

/* rtl/kcma_repeat.sv */
`default_nettype none

`include "keypad_code_map_autorepeat_top_macros.svh"

module kcma_repeat (
  input  var logic                                   clk,
  input  var logic                                   rst,
  input  var logic                                   cfg_we,
  input  var logic [kcma_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  var logic [kcma_pkg::CFG_BITS-1:0]         cfg_data,
  input  var logic                                   advance,
  input  var kcma_pkg::request_t                     req,
  input  var kcma_pkg::key_dec_t                     dec,
  output var logic                                   res_valid,
  output var kcma_pkg::result_t                      res
);
  import kcma_pkg::*;

  logic [CFG_BITS-1:0]    repeat_delay_ms;
  logic [CFG_BITS-1:0]    repeat_period_ms;
  logic                   held_valid;
  logic [BUTTON_BITS-1:0] held_button;
  logic [TIME_BITS-1:0]   since_press;
  logic [TIME_BITS-1:0]   since_repeat;

  logic                   held_valid_next;
  logic [BUTTON_BITS-1:0] held_button_next;
  logic [TIME_BITS-1:0]   since_press_next;
  logic [TIME_BITS-1:0]   since_repeat_next;

  logic [TIME_BITS-1:0]   press_inc;
  logic [TIME_BITS-1:0]   repeat_inc;
  logic                   fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_delay_ms  <= RESET_DELAY;
      repeat_period_ms <= RESET_PERIOD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REPEAT_DELAY:  repeat_delay_ms <= cfg_data;
        CFG_REPEAT_PERIOD: repeat_period_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturating timers.
  assign press_inc  = (&since_press) ? since_press : since_press + 1'b1;
  assign repeat_inc = (&since_repeat) ? since_repeat : since_repeat + 1'b1;
  assign fire = (CMP_BITS'(press_inc) >= CMP_BITS'(repeat_delay_ms))
             && (CMP_BITS'(repeat_inc) >= CMP_BITS'(repeat_period_ms));

  always_comb begin
    held_valid_next   = held_valid;
    held_button_next  = held_button;
    since_press_next  = since_press;
    since_repeat_next = since_repeat;
    res_valid         = 1'b0;
    res.button        = dec.button;
    res.pressed       = dec.press;
    res.is_repeat     = 1'b0;
    if (req.cmd == CMD_TICK) begin
      res.button  = held_button;
      res.pressed = 1'b1;
      if (held_valid) begin
        since_press_next  = press_inc;
        since_repeat_next = fire ? '0 : repeat_inc;
        res_valid         = fire;
        res.is_repeat     = 1'b1;
      end
    end else if (dec.key_ok) begin
      res_valid = 1'b1;
      if (dec.press) begin
        if (dec.button >= DIR_FIRST && dec.button <= DIR_LAST) begin
          held_valid_next   = 1'b1;
          held_button_next  = dec.button;
          since_press_next  = '0;
          since_repeat_next = '0;
        end
      end else if (held_valid && held_button == dec.button) begin
        held_valid_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid   <= 1'b0;
      held_button  <= '0;
      since_press  <= '0;
      since_repeat <= '0;
    end else if (advance) begin
      held_valid   <= held_valid_next;
      held_button  <= held_button_next;
      since_press  <= since_press_next;
      since_repeat <= since_repeat_next;
    end
  end

  `KCMA_ASSERT_NOW(a_held_is_direction, held_valid,
    held_button >= DIR_FIRST && held_button <= DIR_LAST, "held button is not a direction")
  `KCMA_ASSERT_NEXT(a_repeat_restarts, advance && res_valid && res.is_repeat,
    since_repeat == '0, "repeat timer did not restart after a repeat")
  `KCMA_ASSERT_NOW(a_repeat_needs_hold, res_valid && res.is_repeat,
    held_valid && res.pressed, "repeat emitted without a held button")

endmodule

`default_nettype wire

/* rtl/kcma_out_buf.sv */
`default_nettype none

`include "keypad_code_map_autorepeat_top_macros.svh"

module kcma_out_buf (
  input  var logic              clk,
  input  var logic              rst,
  input  var logic              push,
  input  var kcma_pkg::result_t push_data,
  output var logic              space,
  output var logic              out_valid,
  input  var logic              out_ready,
  output var kcma_pkg::result_t out_data
);
  import kcma_pkg::*;

  result_t     entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        pop;

  // Two entries: space depends on registers only, so ready never waits on out_ready.
  assign space     = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = entry[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `KCMA_ASSERT_NOW(a_no_push_when_full, push, count != 2'd2, "result pushed into full buffer")
  `KCMA_ASSERT_NOW(a_count_bound, 1'b1, count <= 2'd2, "result count out of range")
  `KCMA_ASSERT_NOW(a_ptr_count, 1'b1,
    (count == 2'd1) == (wr_ptr != rd_ptr), "pointers disagree with result count")

endmodule

`default_nettype wire

/* dv/keypad_repeat_checker.sv */
`default_nettype none

module keypad_repeat_checker (
  input  var logic                                clk,
  input  var logic                                rst,
  input  var logic                                in_valid,
  input  var logic                                in_ready,
  input  var logic                                cmd,
  input  var logic [kcma_pkg::ETYPE_BITS-1:0]     event_type,
  input  var logic [kcma_pkg::CODE_BITS-1:0]      key_code,
  input  var logic [kcma_pkg::VALUE_BITS-1:0]     key_value,
  input  var logic                                out_valid,
  input  var logic                                out_ready,
  input  var logic [kcma_pkg::BUTTON_BITS-1:0]    button,
  input  var logic                                pressed,
  input  var logic                                is_repeat,
  input  var logic                                cfg_valid,
  input  var logic                                cfg_ready,
  input  var logic [kcma_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  var logic [kcma_pkg::CFG_BITS-1:0]       cfg_data,
  output var int                                  mismatches,
  output var int                                  outstanding
);
  import kcma_pkg::*;

  result_t                expected_keys [$];
  result_t                oldest_key;
  logic [CFG_BITS-1:0]    delay_ms;
  logic [CFG_BITS-1:0]    period_ms;
  logic                   held_valid;
  logic [BUTTON_BITS-1:0] held_button;
  logic [TIME_BITS-1:0]   since_press;
  logic [TIME_BITS-1:0]   since_repeat;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] keypad result mismatch: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Map one request and advance the repeat timers; queue the key result it causes.
  task automatic predict_key_result(input logic                  kind,
                                    input logic [ETYPE_BITS-1:0] etype,
                                    input logic [CODE_BITS-1:0]  code,
                                    input logic [VALUE_BITS-1:0] value);
    int      idx;
    result_t res;
    idx = MAP_SIZE;
    if (kind == CMD_TICK) begin
      if (held_valid) begin
        since_press  = (since_press == '1) ? since_press : since_press + 1'b1;
        since_repeat = (since_repeat == '1) ? since_repeat : since_repeat + 1'b1;
        if (since_press >= delay_ms && since_repeat >= period_ms) begin
          since_repeat = '0;
          res = '{button: held_button, pressed: 1'b1, is_repeat: 1'b1};
          expected_keys.push_back(res);
        end
      end
    end else if (etype == EV_KEY && (value == KEY_PRESS || value == KEY_RELEASE)) begin
      for (int i = MAP_SIZE - 1; i >= 0; i--) begin
        if (CODE_TABLE[i] == code) idx = i;
      end
      if (idx < MAP_SIZE) begin
        if (value == KEY_PRESS) begin
          if (BUTTON_BITS'(idx) >= DIR_FIRST && BUTTON_BITS'(idx) <= DIR_LAST) begin
            held_valid   = 1'b1;
            held_button  = BUTTON_BITS'(idx);
            since_press  = '0;
            since_repeat = '0;
          end
          res = '{button: BUTTON_BITS'(idx), pressed: 1'b1, is_repeat: 1'b0};
        end else begin
          if (held_valid && held_button == BUTTON_BITS'(idx)) held_valid = 1'b0;
          res = '{button: BUTTON_BITS'(idx), pressed: 1'b0, is_repeat: 1'b0};
        end
        expected_keys.push_back(res);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_keys.delete();
      delay_ms     = RESET_DELAY;
      period_ms    = RESET_PERIOD;
      held_valid   = 1'b0;
      held_button  = '0;
      since_press  = '0;
      since_repeat = '0;
    end else begin
      // a result leaves only after its request has passed the input register and the output buffer, so compare first
      if (out_valid && out_ready) begin
        if (expected_keys.size() == 0) begin
          report_mismatch("result with nothing expected, button", int'(button), -1);
        end else begin
          oldest_key = expected_keys.pop_front();
          if (button !== oldest_key.button)
            report_mismatch("button", int'(button), int'(oldest_key.button));
          if (pressed !== oldest_key.pressed)
            report_mismatch("pressed", int'(pressed), int'(oldest_key.pressed));
          if (is_repeat !== oldest_key.is_repeat)
            report_mismatch("is_repeat", int'(is_repeat), int'(oldest_key.is_repeat));
        end
      end
      if (in_valid && in_ready) predict_key_result(cmd, event_type, key_code, key_value);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_REPEAT_DELAY) delay_ms = cfg_data;
        else if (cfg_index == CFG_REPEAT_PERIOD) period_ms = cfg_data;
      end
    end
    outstanding <= expected_keys.size();
  end

endmodule

`default_nettype wire

/* dv/tb.sv */
`default_nettype none

module tb;
  import kcma_pkg::*;

  // Longest legal quiet stretch is the receiver hold-off; leave wide margin.
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 20;
  // Settle after the last result before a register write.
  localparam int SETTLE_CYCLES   = 4;
  // Longest key hold in the random part, in ticks.
  localparam int MAX_HOLD_TICKS  = 450;

  // Key values the block must drop.
  localparam logic [VALUE_BITS-1:0]     KEY_AUTOREPEAT_RAW = VALUE_BITS'(2);
  localparam logic [VALUE_BITS-1:0]     KEY_VALUE_MAX      = VALUE_BITS'(3);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_INDEX   = '1;

  logic                      clk;
  logic                      rst        = 1'b1;
  logic                      in_valid   = 1'b0;
  logic                      in_ready;
  logic                      cmd        = CMD_EVENT;
  logic [ETYPE_BITS-1:0]     event_type = '0;
  logic [CODE_BITS-1:0]      key_code   = '0;
  logic [VALUE_BITS-1:0]     key_value  = '0;
  logic                      out_valid;
  logic                      out_ready  = 1'b0;
  logic [BUTTON_BITS-1:0]    button;
  logic                      pressed;
  logic                      is_repeat;
  logic                      cfg_valid  = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index  = '0;
  logic [CFG_BITS-1:0]       cfg_data   = '0;

  int fail_count;
  int outstanding;

  // Idle odds in percent, and the register values last written.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cur_delay     = RESET_DELAY;
  int cur_period    = RESET_PERIOD;
  bit stall_request = 1'b0;

  keypad_code_map_autorepeat_top u_top (.*);

  keypad_repeat_checker u_checker (
    .*,
    .mismatches(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one request; hold valid and payload until the block takes it.
  task automatic send_request(input cmd_t                  kind,
                              input logic [ETYPE_BITS-1:0] etype,
                              input logic [CODE_BITS-1:0]  code,
                              input logic [VALUE_BITS-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= kind;
    event_type <= etype;
    key_code   <= code;
    key_value  <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_key(input logic [CODE_BITS-1:0] code, input logic [VALUE_BITS-1:0] value);
    send_request(CMD_EVENT, EV_KEY, code, value);
  endtask

  // Tick with junk in the fields the block must ignore.
  task automatic send_tick();
    send_request(CMD_TICK, ETYPE_BITS'($urandom), CODE_BITS'($urandom), VALUE_BITS'($urandom));
  endtask

  // Drop valid, then hold until every expected result is out and the pipe is empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [CFG_BITS-1:0]       data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write both timing registers while idle; optionally poke an unused index too.
  task automatic configure(input logic [CFG_BITS-1:0] delay,
                           input logic [CFG_BITS-1:0] period,
                           input bit                  poke_unused);
    wait_idle();
    write_reg(CFG_REPEAT_DELAY, delay);
    if (poke_unused) write_reg(CFG_UNUSED_INDEX, ~delay);
    write_reg(CFG_REPEAT_PERIOD, period);
    cfg_valid  <= 1'b0;
    cur_delay  = delay;
    cur_period = period;
  endtask

  // Mostly held direction keys with tick runs around the repeat point,
  // mixed with stray keys and noise that the block must drop.
  task automatic run_random(input int budget);
    int                     done;
    int                     kind;
    int                     span;
    int                     ticks;
    logic [BUTTON_BITS-1:0] dir;
    logic [BUTTON_BITS-1:0] other;
    done = 0;
    while (done < budget) begin
      kind  = $urandom_range(99);
      other = BUTTON_BITS'($urandom_range(MAP_SIZE - 1));
      if (kind < 55) begin
        dir  = DIR_FIRST + BUTTON_BITS'($urandom_range(3));
        span = cur_delay + 2 * cur_period + 3;
        if (span > MAX_HOLD_TICKS) span = MAX_HOLD_TICKS;
        ticks = $urandom_range(span);
        send_key(CODE_TABLE[dir], KEY_PRESS);
        for (int k = 0; k < ticks; k++) begin
          // now and then another key lands mid-hold, possibly the held one
          if ($urandom_range(19) == 0)
            send_key(CODE_TABLE[BUTTON_BITS'($urandom_range(MAP_SIZE - 1))],
                     VALUE_BITS'($urandom_range(1)));
          else
            send_tick();
        end
        // usually release the held key, sometimes a different one
        send_key(CODE_TABLE[($urandom_range(3) == 0) ? other : dir], KEY_RELEASE);
        done += ticks + 2;
      end else if (kind < 80) begin
        send_key(CODE_TABLE[other], VALUE_BITS'($urandom_range(1)));
        done++;
      end else if (kind < 90) begin
        send_tick();
        done++;
      end else begin
        // noise: any class, any value, half the time a mapped code
        send_request(CMD_EVENT, ETYPE_BITS'($urandom),
                     $urandom_range(1) ? CODE_TABLE[other] : CODE_BITS'($urandom),
                     VALUE_BITS'($urandom));
        done++;
      end
    end
  endtask

  // Receiver: random ready, plus one long hold-off on request.
  initial begin : receiver
    int stall_count;
    stall_count = 0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        stall_count   = HOLD_OFF_CYCLES;
      end
      if (stall_count > 0) begin
        stall_count--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run if no request, result or write moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 26;
    recv_idle_pct = 76;
    @(posedge clk);

    // Dropped items: tick with nothing held, non-key classes, odd values, unmapped codes.
    send_tick();
    send_request(CMD_EVENT, '0, CODE_TABLE[DIR_FIRST], KEY_PRESS);
    send_request(CMD_EVENT, '1, CODE_TABLE[DIR_FIRST], KEY_PRESS);
    send_key(CODE_TABLE[0], KEY_AUTOREPEAT_RAW);
    send_key(CODE_TABLE[0], KEY_VALUE_MAX);
    send_key('0, KEY_PRESS);
    send_key('1, KEY_PRESS);
    // Non-direction keys at both ends of the table: result, hold untouched.
    send_key(CODE_TABLE[0], KEY_PRESS);
    send_key(CODE_TABLE[0], KEY_RELEASE);
    send_key(CODE_TABLE[MAP_SIZE-1], KEY_PRESS);
    send_key(CODE_TABLE[MAP_SIZE-1], KEY_RELEASE);
    // A second direction takes over the hold; releasing the first keeps it.
    send_key(CODE_TABLE[DIR_FIRST], KEY_PRESS);
    send_request(CMD_TICK, '1, '1, KEY_VALUE_MAX);
    send_key(CODE_TABLE[DIR_LAST], KEY_PRESS);
    send_key(CODE_TABLE[DIR_FIRST], KEY_RELEASE);
    send_tick();
    send_key(CODE_TABLE[DIR_LAST], KEY_RELEASE);
    send_tick();
    run_random(350);

    // Zero delay and period: a repeat on every tick while held.
    configure('0, '0, 1'b0);
    send_key(CODE_TABLE[DIR_FIRST+1], KEY_PRESS);
    send_tick();
    send_tick();
    send_tick();
    send_key(CODE_TABLE[0], KEY_PRESS);
    send_tick();
    send_key(CODE_TABLE[0], KEY_RELEASE);
    send_key(CODE_TABLE[DIR_FIRST+1], KEY_RELEASE);
    send_tick();
    run_random(100);

    // Short timings; hold the receiver off while requests keep coming so the block backs up.
    configure(CFG_BITS'(3), CFG_BITS'(2), 1'b0);
    run_random(60);
    stall_request = 1'b1;
    send_idle_pct = 0;
    run_random(40);
    send_idle_pct = 26;
    run_random(60);

    // Swap the idle odds.
    send_idle_pct = 76;
    recv_idle_pct = 26;
    configure(CFG_BITS'(1), CFG_BITS'(5), 1'b1);
    run_random(150);
    configure(CFG_BITS'(10), CFG_BITS'(1), 1'b0);
    run_random(150);
    configure(CFG_BITS'(7), '0, 1'b1);
    run_random(150);

    // No idling from here on.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(CFG_BITS'($urandom_range(20)), CFG_BITS'($urandom_range(12)), 1'b0);
    run_random(130);

    // Both registers at maximum: no repeat within reach.
    configure('1, '1, 1'b1);
    run_random(60);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+rtl
rtl/kcma_pkg.sv
rtl/kcma_decode.sv
rtl/kcma_repeat.sv
rtl/kcma_out_buf.sv
rtl/keypad_code_map_autorepeat_top.sv
dv/keypad_repeat_checker.sv
dv/tb.sv
